// ----- rtl/lira_pkg.sv -----
// ----------------------------------------------------------------------------
// lira_pkg
// Types and constants shared by the lookup-table remap address generator.
// ----------------------------------------------------------------------------
package lira_pkg;

  localparam int COORD_W      = 12;  // pixel coordinates
  localparam int CFG_W        = 13;  // configuration values
  localparam int DIM_W        = 14;  // rounded width and pitch, up to 8192
  localparam int IDX_W        = 27;  // y * w + x before the range check
  localparam int ENTRY_W      = 25;  // valid, source y, source x
  localparam int DST_LUMA_W   = 24;
  localparam int DST_CHROMA_W = 23;
  localparam int SRC_ADDR_W   = 25;
  localparam int S_TDATA_W    = 56;
  localparam int M_TDATA_W    = 128;
  localparam int M_TUSER_W    = 2;
  localparam int CFG_IDX_W    = 3;
  localparam int M_USED_W     = DST_LUMA_W + SRC_ADDR_W + DST_CHROMA_W + 2 * SRC_ADDR_W;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_DEST_WIDTH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_LUMA_PITCH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_CB_PITCH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_CR_PITCH   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CHROMA_MODE    = 3'd6;

  // Chroma modes
  localparam logic [1:0] CM_GREY = 2'd0;
  localparam logic [1:0] CM_420  = 2'd1;
  localparam logic [1:0] CM_422  = 2'd2;

  // Request types
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_PIXEL = 1'b1;

  typedef struct packed {
    logic [CFG_W-1:0] dest_width;
    logic [CFG_W-1:0] src_width;
    logic [CFG_W-1:0] src_height;
    logic [CFG_W-1:0] src_luma_pitch;
    logic [CFG_W-1:0] src_cb_pitch;
    logic [CFG_W-1:0] src_cr_pitch;
    logic [1:0]       chroma_mode;
  } cfg_t;

  typedef struct packed {
    logic               req_type;
    logic [COORD_W-1:0] dest_x;
    logic [COORD_W-1:0] dest_y;
    logic [COORD_W-1:0] load_src_x;
    logic [COORD_W-1:0] load_src_y;
    logic               load_valid;
  } item_t;

  typedef struct packed {
    logic                    ok;
    logic [IDX_W-1:0]        idx;
    logic [DST_LUMA_W-1:0]   dst_luma_addr;
    logic [DST_CHROMA_W-1:0] dst_chroma_addr;
  } dst_info_t;

  typedef struct packed {
    logic                    hit;
    logic [DST_LUMA_W-1:0]   dst_luma_addr;
    logic [SRC_ADDR_W-1:0]   src_luma_addr;
    logic                    chroma_present;
    logic [DST_CHROMA_W-1:0] dst_chroma_addr;
    logic [SRC_ADDR_W-1:0]   src_cb_addr;
    logic [SRC_ADDR_W-1:0]   src_cr_addr;
  } result_t;

endpackage

// ----- rtl/lira_ram.sv -----
// ----------------------------------------------------------------------------
// lira_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module lira_ram #(
  parameter int WIDTH = 25,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/lira_dst_calc.sv -----
// ----------------------------------------------------------------------------
// lira_dst_calc
// Map index, range check and destination addresses for one item.
// ----------------------------------------------------------------------------
module lira_dst_calc #(
  parameter int MAX_DIM     = 4096,
  parameter int MAP_ENTRIES = 1048576
) (
  input  lira_pkg::cfg_t      cfg,
  input  lira_pkg::item_t     item,
  output lira_pkg::dst_info_t info
);
  import lira_pkg::*;

  logic [DIM_W-1:0]              w_sum;
  logic [DIM_W-1:0]              w;
  logic [DIM_W-1:0]              p_sum;
  logic [DIM_W-1:0]              pitch;
  logic [COORD_W+DIM_W-1:0]      y_w;
  logic [COORD_W+DIM_W-1:0]      y_pitch;
  logic [COORD_W-1:0]            y_c;
  logic [COORD_W+DIM_W-2:0]      yc_pitch;

  always_comb begin
    // round the width up to 8, the pitch up to 16
    w_sum = {1'b0, cfg.dest_width} + DIM_W'(7);
    w     = {w_sum[DIM_W-1:3], 3'b000};
    p_sum = w + DIM_W'(15);
    pitch = {p_sum[DIM_W-1:4], 4'b0000};

    y_w      = item.dest_y * w;
    info.idx = {1'b0, y_w} + IDX_W'(item.dest_x);
    info.ok  = ({2'b00, item.dest_x} < w)
            && ({2'b00, item.dest_y} < DIM_W'(MAX_DIM))
            && (info.idx < IDX_W'(MAP_ENTRIES));

    y_pitch            = item.dest_y * pitch;
    info.dst_luma_addr = y_pitch[DST_LUMA_W-1:0] + DST_LUMA_W'(item.dest_x);

    y_c      = (cfg.chroma_mode == CM_420) ? (item.dest_y >> 1) : item.dest_y;
    yc_pitch = y_c * pitch[DIM_W-1:1];
    info.dst_chroma_addr = yc_pitch[DST_CHROMA_W-1:0]
                         + DST_CHROMA_W'(item.dest_x[COORD_W-1:1]);
  end

endmodule

// ----- rtl/lira_src_calc.sv -----
// ----------------------------------------------------------------------------
// lira_src_calc
// Bounds check of a map entry and source plane addresses.
// ----------------------------------------------------------------------------
module lira_src_calc (
  input  lira_pkg::cfg_t                   cfg,
  input  lira_pkg::dst_info_t              dst,
  input  logic [lira_pkg::ENTRY_W-1:0]     entry,
  output lira_pkg::result_t                res
);
  import lira_pkg::*;

  logic [COORD_W-1:0]       sx;
  logic [COORD_W-1:0]       sy;
  logic [COORD_W-1:0]       sy_c;
  logic [COORD_W+CFG_W-1:0] luma_prod;
  logic [COORD_W+CFG_W-1:0] cb_prod;
  logic [COORD_W+CFG_W-1:0] cr_prod;
  logic                     hit;
  logic                     chroma_on;

  always_comb begin
    sx   = entry[COORD_W-1:0];
    sy   = entry[2*COORD_W-1:COORD_W];
    sy_c = (cfg.chroma_mode == CM_420) ? (sy >> 1) : sy;

    hit = dst.ok && entry[ENTRY_W-1]
       && ({1'b0, sx} < cfg.src_width)
       && ({1'b0, sy} < cfg.src_height);
    chroma_on = (cfg.chroma_mode == CM_420) || (cfg.chroma_mode == CM_422);

    luma_prod = sy * cfg.src_luma_pitch;
    cb_prod   = sy_c * cfg.src_cb_pitch;
    cr_prod   = sy_c * cfg.src_cr_pitch;

    res = '0;
    if (hit) begin
      res.hit           = 1'b1;
      res.dst_luma_addr = dst.dst_luma_addr;
      res.src_luma_addr = luma_prod[SRC_ADDR_W-1:0] + SRC_ADDR_W'(sx);
      if (chroma_on) begin
        res.chroma_present  = 1'b1;
        res.dst_chroma_addr = dst.dst_chroma_addr;
        res.src_cb_addr     = cb_prod[SRC_ADDR_W-1:0] + SRC_ADDR_W'(sx[COORD_W-1:1]);
        res.src_cr_addr     = cr_prod[SRC_ADDR_W-1:0] + SRC_ADDR_W'(sx[COORD_W-1:1]);
      end
    end
  end

endmodule

// ----- rtl/lut_image_remap_address_gen.sv -----
// ----------------------------------------------------------------------------
// lut_image_remap_address_gen
// Lookup-table image remapper: loads map entries and turns destination
// pixels into luma and chroma source / destination byte offsets.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  s_*      in         s_tvalid / s_tready    s_tdata, s_tuser (request type)
//  m_*      out        m_tvalid / m_tready    m_tdata, m_tuser (hit, chroma)
//  cfg_*    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  One item per clock unless a stalled output has filled the stages. A pixel
//  result passes the input register, the map store read and the result
//  register in that order. A load item writes the store as it leaves the
//  input register and gives no result. The map store contents are undefined
//  after reset and take no clearing pass. Reset clears the stage valids and
//  loads the register defaults. A stalled output only blocks the stages
//  behind it once they are full.
// ----------------------------------------------------------------------------
module lut_image_remap_address_gen #(
  parameter int MAX_DIM     = 4096,
  parameter int MAP_ENTRIES = 1048576
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // dest_x[11:0], dest_y[23:12], load_src_x[35:24], load_src_y[47:36],
  // load_valid[48], zero[55:49]
  input  logic [lira_pkg::S_TDATA_W-1:0]     s_tdata,
  // req_type[0]
  input  logic                               s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // dst_luma_addr[23:0], src_luma_addr[48:24], dst_chroma_addr[71:49],
  // src_cb_addr[96:72], src_cr_addr[121:97], zero[127:122]
  output logic [lira_pkg::M_TDATA_W-1:0]     m_tdata,
  // hit[0], chroma_present[1]
  output logic [lira_pkg::M_TUSER_W-1:0]     m_tuser,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lira_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lira_pkg::CFG_W-1:0]         cfg_data
);
  import lira_pkg::*;

  localparam int ADDR_W = $clog2(MAP_ENTRIES);

  cfg_t               cfg;
  item_t              s1_item;
  logic               s1_v;
  dst_info_t          dst_info;
  dst_info_t          s2_dst;
  logic               s2_v;
  logic [ENTRY_W-1:0] entry;
  result_t            res;
  result_t            s3_res;
  logic               s3_v;

  logic s3_ready;
  logic s2_ready;
  logic s1_fire;
  logic s1_fire_pix;
  logic s2_fire;
  logic map_we;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dest_width     <= CFG_W'(640);
      cfg.src_width      <= CFG_W'(640);
      cfg.src_height     <= CFG_W'(480);
      cfg.src_luma_pitch <= CFG_W'(640);
      cfg.src_cb_pitch   <= CFG_W'(320);
      cfg.src_cr_pitch   <= CFG_W'(320);
      cfg.chroma_mode    <= CM_GREY;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DEST_WIDTH:     cfg.dest_width     <= cfg_data;
        REG_SRC_WIDTH:      cfg.src_width      <= cfg_data;
        REG_SRC_HEIGHT:     cfg.src_height     <= cfg_data;
        REG_SRC_LUMA_PITCH: cfg.src_luma_pitch <= cfg_data;
        REG_SRC_CB_PITCH:   cfg.src_cb_pitch   <= cfg_data;
        REG_SRC_CR_PITCH:   cfg.src_cr_pitch   <= cfg_data;
        REG_CHROMA_MODE:    cfg.chroma_mode    <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Stage flow: loads retire from stage 1, pixels move on to the output
  assign s3_ready    = !s3_v || m_tready;
  assign s2_ready    = !s2_v || s3_ready;
  assign s1_fire     = s1_v && ((s1_item.req_type == REQ_LOAD) || s2_ready);
  assign s1_fire_pix = s1_fire && (s1_item.req_type == REQ_PIXEL);
  assign s2_fire     = s2_v && s3_ready;
  assign s_tready    = !s1_v || s1_fire;
  assign map_we      = s1_fire && (s1_item.req_type == REQ_LOAD) && dst_info.ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (s_tready) begin
      s1_v <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_item.req_type   <= s_tuser;
      s1_item.dest_x     <= s_tdata[11:0];
      s1_item.dest_y     <= s_tdata[23:12];
      s1_item.load_src_x <= s_tdata[35:24];
      s1_item.load_src_y <= s_tdata[47:36];
      s1_item.load_valid <= s_tdata[48];
    end
  end

  lira_dst_calc #(
    .MAX_DIM     (MAX_DIM),
    .MAP_ENTRIES (MAP_ENTRIES)
  ) u_dst_calc (
    .cfg  (cfg),
    .item (s1_item),
    .info (dst_info)
  );

  lira_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAP_ENTRIES)
  ) u_map_store (
    .clk   (clk),
    .we    (map_we),
    .waddr (dst_info.idx[ADDR_W-1:0]),
    .wdata ({s1_item.load_valid, s1_item.load_src_y, s1_item.load_src_x}),
    .re    (s1_fire_pix),
    .raddr (dst_info.idx[ADDR_W-1:0]),
    .rdata (entry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (s1_fire_pix) begin
      s2_v <= 1'b1;
    end else if (s2_fire) begin
      s2_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire_pix) begin
      s2_dst <= dst_info;
    end
  end

  lira_src_calc u_src_calc (
    .cfg   (cfg),
    .dst   (s2_dst),
    .entry (entry),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (s2_fire) begin
      s3_v <= 1'b1;
    end else if (m_tready) begin
      s3_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      s3_res <= res;
    end
  end

  assign m_tvalid = s3_v;
  assign m_tuser  = {s3_res.chroma_present, s3_res.hit};
  assign m_tdata  = {(M_TDATA_W - M_USED_W)'(0), s3_res.src_cr_addr, s3_res.src_cb_addr,
                     s3_res.dst_chroma_addr, s3_res.src_luma_addr, s3_res.dst_luma_addr};

endmodule

// ----- rtl/lira_checker.sv -----
// ----------------------------------------------------------------------------
// lira_checker
// Port-level checks on the remap address generator's result stream.
// ----------------------------------------------------------------------------
module lira_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [lira_pkg::M_TDATA_W-1:0] m_tdata,
  input logic [lira_pkg::M_TUSER_W-1:0] m_tuser
);
  import lira_pkg::*;

  localparam int CHROMA_LO = DST_LUMA_W + SRC_ADDR_W;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // a miss carries no addresses and no chroma flag
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> (m_tdata == '0) && !m_tuser[1])
    else $error("miss with nonzero payload");

  // no chroma flag, no chroma addresses
  a_chroma_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[1] |-> (m_tdata[M_USED_W-1:CHROMA_LO] == '0))
    else $error("chroma addresses without chroma flag");

  // drop every result on reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind lut_image_remap_address_gen lira_checker u_lira_checker (.*);
